// File: sv/at_ipd_frame_parser_macros.svh
// ----------------------------------------------------------------------------
// at_ipd_frame_parser_macros
// assertion macros used by the frame parser core (ipd_parse_core)
// ----------------------------------------------------------------------------
`ifndef AT_IPD_FRAME_PARSER_MACROS_SVH
`define AT_IPD_FRAME_PARSER_MACROS_SVH

// same-cycle implication, off while in reset
`define IPD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("at_ipd_frame_parser: same-cycle check failed");

// next-cycle implication, off while in reset
`define IPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("at_ipd_frame_parser: next-cycle check failed");

`endif

// File: sv/ipd_pkg.sv
// ----------------------------------------------------------------------------
// ipd_pkg
// types and constants of the +IPD frame parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ipd_pkg;

    localparam int BYTE_W          = 8;
    localparam int CFG_W           = 16;
    localparam int LEN_CHARS_DEF   = 9;
    localparam int LENGTH_W_DEF    = 16;

    localparam logic [CFG_W-1:0]  MAX_PAYLOAD_RST = 16'd2920;

    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

    localparam logic [0:0] KIND_DATA    = 1'b0;
    localparam logic [0:0] KIND_BAD_LEN = 1'b1;

    typedef struct packed {
        logic              valid;
        logic [0:0]        kind;
        logic [BYTE_W-1:0] payload_byte;
        logic              last;
    } t_result;

    // the four characters after '+': "IPD,"
    function automatic logic [BYTE_W-1:0] prefix_tail(input logic [1:0] idx);
        logic [BYTE_W-1:0] ch;
        case (idx)
            2'd0:    ch = 8'h49;
            2'd1:    ch = 8'h50;
            2'd2:    ch = 8'h44;
            default: ch = 8'h2C;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// File: sv/ipd_parse_core.sv
// ----------------------------------------------------------------------------
// ipd_parse_core
// parser state and the per-byte update, one byte per transaction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "at_ipd_frame_parser_macros.svh"

module ipd_parse_core #(
    parameter int LEN_FIELD_CHARS = ipd_pkg::LEN_CHARS_DEF,
    parameter int LENGTH_WIDTH    = ipd_pkg::LENGTH_W_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_fire,
    input  wire logic [ipd_pkg::BYTE_W-1:0] i_byte,
    input  wire logic [ipd_pkg::CFG_W-1:0]  i_max_payload,
    output ipd_pkg::t_result                o_res
);

    localparam int ACC_W = LENGTH_WIDTH + 1;
    localparam int MUL_W = LENGTH_WIDTH + 5;
    localparam int CMP_W = (ACC_W > ipd_pkg::CFG_W) ? ACC_W : ipd_pkg::CFG_W;

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;

    localparam logic [3:0]       LEN_CHARS = 4'(LEN_FIELD_CHARS);
    localparam logic [ACC_W-1:0] ACC_CAP   = {1'b1, {LENGTH_WIDTH{1'b0}}};

    logic [1:0]              r_phase,      n_phase;
    logic [3:0]              r_char_pos,   n_char_pos;
    logic                    r_prefix_bad, n_prefix_bad;
    logic [ACC_W-1:0]        r_length_acc, n_length_acc;
    logic                    r_digits_bad, n_digits_bad;
    logic [LENGTH_WIDTH-1:0] r_bytes_left, n_bytes_left;

    logic                    is_digit;
    logic [MUL_W-1:0]        acc_times_ten;
    logic                    len_bad;
    logic                    pre_bad;
    logic [LENGTH_WIDTH-1:0] left_dec;

    assign is_digit = (i_byte >= ipd_pkg::CH_ZERO) && (i_byte <= ipd_pkg::CH_NINE);
    // low nibble of '0'..'9' is the digit value
    assign acc_times_ten = (MUL_W'(r_length_acc) << 3) + (MUL_W'(r_length_acc) << 1)
                         + MUL_W'(i_byte[3:0]);
    assign len_bad = (r_char_pos == 4'd0) || r_digits_bad || (r_length_acc == '0)
                   || (CMP_W'(r_length_acc) > CMP_W'(i_max_payload));
    assign pre_bad = r_prefix_bad
                   || (i_byte != ipd_pkg::prefix_tail(2'(r_char_pos - 4'd1)));
    assign left_dec = (r_bytes_left != '0) ? (r_bytes_left - LENGTH_WIDTH'(1)) : r_bytes_left;

    always_comb begin
        n_phase      = r_phase;
        n_char_pos   = r_char_pos;
        n_prefix_bad = r_prefix_bad;
        n_length_acc = r_length_acc;
        n_digits_bad = r_digits_bad;
        n_bytes_left = r_bytes_left;
        o_res        = '0;

        case (r_phase)
            PH_LEN: begin
                if (i_byte == ipd_pkg::CH_COLON) begin
                    n_char_pos   = 4'd0;
                    n_length_acc = '0;
                    n_digits_bad = 1'b0;
                    if (len_bad) begin
                        n_phase      = PH_HUNT;
                        n_prefix_bad = 1'b0;
                        n_bytes_left = '0;
                        o_res.valid  = 1'b1;
                        o_res.kind   = ipd_pkg::KIND_BAD_LEN;
                    end else begin
                        n_phase      = PH_DATA;
                        n_bytes_left = r_length_acc[LENGTH_WIDTH-1:0];
                    end
                end else if (r_char_pos >= LEN_CHARS) begin
                    // no colon in time: back to the hunt without a result
                    n_phase      = PH_HUNT;
                    n_char_pos   = 4'd0;
                    n_prefix_bad = 1'b0;
                    n_length_acc = '0;
                    n_digits_bad = 1'b0;
                    n_bytes_left = '0;
                end else begin
                    if (is_digit) begin
                        n_length_acc = (acc_times_ten > MUL_W'(ACC_CAP))
                                     ? ACC_CAP : acc_times_ten[ACC_W-1:0];
                    end else begin
                        n_digits_bad = 1'b1;
                    end
                    n_char_pos = r_char_pos + 4'd1;
                end
            end
            PH_DATA: begin
                o_res.valid        = 1'b1;
                o_res.kind         = ipd_pkg::KIND_DATA;
                o_res.payload_byte = i_byte;
                o_res.last         = (left_dec == '0);
                n_bytes_left       = left_dec;
                if (left_dec == '0) begin
                    n_phase      = PH_HUNT;
                    n_char_pos   = 4'd0;
                    n_prefix_bad = 1'b0;
                    n_length_acc = '0;
                    n_digits_bad = 1'b0;
                end
            end
            default: begin
                n_phase = PH_HUNT;
                if (r_char_pos == 4'd0) begin
                    if (i_byte == ipd_pkg::CH_PLUS) begin
                        n_char_pos   = 4'd1;
                        n_prefix_bad = 1'b0;
                    end
                end else if (r_char_pos >= 4'd4) begin
                    // fifth byte decides, no early resync on a mismatch
                    n_phase      = pre_bad ? PH_HUNT : PH_LEN;
                    n_char_pos   = 4'd0;
                    n_prefix_bad = 1'b0;
                    n_length_acc = '0;
                    n_digits_bad = 1'b0;
                    n_bytes_left = '0;
                end else begin
                    n_prefix_bad = pre_bad;
                    n_char_pos   = r_char_pos + 4'd1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HUNT;
            r_char_pos   <= 4'd0;
            r_prefix_bad <= 1'b0;
            r_length_acc <= '0;
            r_digits_bad <= 1'b0;
            r_bytes_left <= '0;
        end else if (i_fire) begin
            r_phase      <= n_phase;
            r_char_pos   <= n_char_pos;
            r_prefix_bad <= n_prefix_bad;
            r_length_acc <= n_length_acc;
            r_digits_bad <= n_digits_bad;
            r_bytes_left <= n_bytes_left;
        end
    end

    `IPD_ASSERT_NEXT(a_frame_ends_in_hunt, i_clk, i_rst_n, i_fire && (r_phase == PH_DATA) && (r_bytes_left <= LENGTH_WIDTH'(1)), r_phase == PH_HUNT)
    `IPD_ASSERT_NOW(a_bad_len_on_colon, i_clk, i_rst_n, i_fire && o_res.valid && (o_res.kind == ipd_pkg::KIND_BAD_LEN), (r_phase == PH_LEN) && (i_byte == ipd_pkg::CH_COLON) && !o_res.last)
    `IPD_ASSERT_NOW(a_len_field_bound, i_clk, i_rst_n, r_phase == PH_LEN, r_char_pos <= LEN_CHARS)

endmodule

`default_nettype wire

// File: sv/at_ipd_frame_parser.sv
// ----------------------------------------------------------------------------
// at_ipd_frame_parser
// extracts payloads of "+IPD,<length>:<payload>" frames from a modem byte stream
// ----------------------------------------------------------------------------
// channel | direction | signals
// rx      | in        | i_rx_valid, o_rx_ready, i_rx_byte
// out     | out       | o_out_valid, i_out_ready, o_kind, o_payload_byte, o_last_in_frame
// cfg     | in        | i_cfg_valid, o_cfg_ready, i_cfg_max_payload
//
// one byte per cycle sustained while the output register is being taken
// the input register feeds one pass of parser logic into the output register
// the input register moves on whenever the output register is empty or being taken
// synchronous active-low reset; max_payload resets to 2920
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module at_ipd_frame_parser #(
    parameter int LEN_FIELD_CHARS = ipd_pkg::LEN_CHARS_DEF,
    parameter int LENGTH_WIDTH    = ipd_pkg::LENGTH_W_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_rx_valid,
    output wire logic                       o_rx_ready,
    input  wire logic [ipd_pkg::BYTE_W-1:0] i_rx_byte,
    output wire logic                       o_out_valid,
    input  wire logic                       i_out_ready,
    output wire logic                       o_kind,
    output wire logic [ipd_pkg::BYTE_W-1:0] o_payload_byte,
    output wire logic                       o_last_in_frame,
    input  wire logic                       i_cfg_valid,
    output wire logic                       o_cfg_ready,
    input  wire logic [ipd_pkg::CFG_W-1:0]  i_cfg_max_payload
);

    logic                       r_in_valid;
    logic [ipd_pkg::BYTE_W-1:0] r_in_byte;
    logic                       r_out_valid;
    logic [0:0]                 r_out_kind;
    logic [ipd_pkg::BYTE_W-1:0] r_out_byte;
    logic                       r_out_last;
    logic [ipd_pkg::CFG_W-1:0]  r_max_payload;

    ipd_pkg::t_result           core_res;
    logic                       out_free;
    logic                       fire;
    logic                       rx_take;

    assign out_free = !r_out_valid || i_out_ready;
    assign fire     = r_in_valid && out_free;
    assign rx_take  = i_rx_valid && o_rx_ready;

    assign o_rx_ready      = !r_in_valid || out_free;
    assign o_cfg_ready     = 1'b1;
    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_out_kind[0];
    assign o_payload_byte  = r_out_byte;
    assign o_last_in_frame = r_out_last;

    ipd_parse_core #(
        .LEN_FIELD_CHARS (LEN_FIELD_CHARS),
        .LENGTH_WIDTH    (LENGTH_WIDTH)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_byte        (r_in_byte),
        .i_max_payload (r_max_payload),
        .o_res         (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (rx_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_take) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // bytes that give no result leave the output register empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= core_res.valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_kind <= core_res.kind;
            r_out_byte <= core_res.payload_byte;
            r_out_last <= core_res.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= ipd_pkg::MAX_PAYLOAD_RST;
        end else if (i_cfg_valid) begin
            r_max_payload <= i_cfg_max_payload;
        end
    end

endmodule

`default_nettype wire
